// ===== hw/rtl/rvalu_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rvalu_pkg
// Shared types, codes and helpers for the RV32I register ALU execute core.
// ---------------------------------------------------------------------------
package rvalu_pkg;

   localparam int XLEN          = 32;
   localparam int IDX_W         = 5;
   localparam int REG_COUNT_DEF = 32;

   typedef enum logic [1:0] {
      FUNC_EXEC = 2'd0,
      FUNC_LOAD = 2'd1,
      FUNC_READ = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_MULDIV   = 2'd1,
      ST_RESERVED = 2'd2
   } status_type;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [6:0] F7_BASE   = 7'b0000000;
   localparam logic [6:0] F7_ALT    = 7'b0100000;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;

   typedef struct packed {
      logic [1:0]      func;
      logic [XLEN-1:0] instruction_word;
      logic [IDX_W-1:0] reg_index;
      logic [XLEN-1:0] reg_value;
   } req_type;

   typedef struct packed {
      logic            wrote;
      logic [IDX_W-1:0] dest_index;
      logic [XLEN-1:0] result_value;
      logic [1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic            en;
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
   } rd_req_type;

   typedef struct packed {
      logic            en;
      logic [IDX_W-1:0] idx;
      logic [XLEN-1:0] data;
   } wr_req_type;

   // x0 and numbers past the implemented count are not real registers
   function automatic logic reg_ok(input logic [IDX_W-1:0] idx, input int unsigned count);
      return (idx != '0) && (32'(idx) < count);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rvalu_req_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rvalu_req_if
// Request channel: function select, instruction word and register access.
// ---------------------------------------------------------------------------
interface rvalu_req_if;
   import rvalu_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       func;
   logic [XLEN-1:0]  instruction_word;
   logic [IDX_W-1:0] reg_index;
   logic [XLEN-1:0]  reg_value;

   modport source (output valid, func, instruction_word, reg_index, reg_value, input ready);
   modport sink   (input valid, func, instruction_word, reg_index, reg_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rvalu_rsp_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rvalu_rsp_if
// Response channel: write flag, destination, result and status.
// ---------------------------------------------------------------------------
interface rvalu_rsp_if;
   import rvalu_pkg::*;

   logic             valid;
   logic             ready;
   logic             wrote;
   logic [IDX_W-1:0] dest_index;
   logic [XLEN-1:0]  result_value;
   logic [1:0]       status;

   modport source (output valid, wrote, dest_index, result_value, status, input ready);
   modport sink   (input valid, wrote, dest_index, result_value, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rvalu_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rvalu_ram
// Generic RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module rvalu_ram #(
   parameter int WIDTH = rvalu_pkg::XLEN,
   parameter int DEPTH = rvalu_pkg::REG_COUNT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]              rd_data_a,
   output logic [WIDTH-1:0]              rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rvalu_regfile.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rvalu_regfile
// Register file: RAM storage, per-entry valid bits cleared at reset, and
// forwarding of a write that lands on the same edge as a read.
// ---------------------------------------------------------------------------
module rvalu_regfile #(
   parameter int REG_COUNT = rvalu_pkg::REG_COUNT_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rvalu_pkg::rd_req_type      rd_req,
   input  wire rvalu_pkg::wr_req_type      wr_req,
   output logic [rvalu_pkg::XLEN-1:0]      opnd_a,
   output logic [rvalu_pkg::XLEN-1:0]      opnd_b
);
   import rvalu_pkg::*;

   localparam int ADDR_W = $clog2(REG_COUNT);

   logic                 we;
   logic [ADDR_W-1:0]    waddr;
   logic [ADDR_W-1:0]    raddr_a;
   logic [ADDR_W-1:0]    raddr_b;
   logic [XLEN-1:0]      q_a;
   logic [XLEN-1:0]      q_b;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic                 hit_a_ff, hit_a_in;
   logic                 hit_b_ff, hit_b_in;
   logic                 live_a_ff, live_a_in;
   logic                 live_b_ff, live_b_in;
   logic [XLEN-1:0]      fwd_data_ff, fwd_data_in;

   assign we      = wr_req.en && reg_ok(wr_req.idx, REG_COUNT);
   assign waddr   = wr_req.idx[ADDR_W-1:0];
   assign raddr_a = rd_req.idx_a[ADDR_W-1:0];
   assign raddr_b = rd_req.idx_b[ADDR_W-1:0];

   rvalu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (waddr),
      .wr_data   (wr_req.data),
      .rd_en     (rd_req.en),
      .rd_addr_a (raddr_a),
      .rd_addr_b (raddr_b),
      .rd_data_a (q_a),
      .rd_data_b (q_b)
   );

   always_comb begin
      valid_in    = valid_ff;
      hit_a_in    = hit_a_ff;
      hit_b_in    = hit_b_ff;
      live_a_in   = live_a_ff;
      live_b_in   = live_b_ff;
      fwd_data_in = fwd_data_ff;
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
      if (rd_req.en) begin
         // RAM returns old data on a same-edge write; take the write instead
         hit_a_in    = we && (wr_req.idx == rd_req.idx_a);
         hit_b_in    = we && (wr_req.idx == rd_req.idx_b);
         live_a_in   = reg_ok(rd_req.idx_a, REG_COUNT) && valid_ff[raddr_a];
         live_b_in   = reg_ok(rd_req.idx_b, REG_COUNT) && valid_ff[raddr_b];
         fwd_data_in = wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         hit_a_ff  <= 1'b0;
         hit_b_ff  <= 1'b0;
         live_a_ff <= 1'b0;
         live_b_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         hit_a_ff  <= hit_a_in;
         hit_b_ff  <= hit_b_in;
         live_a_ff <= live_a_in;
         live_b_ff <= live_b_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
   end

   assign opnd_a = hit_a_ff ? fwd_data_ff : (live_a_ff ? q_a : '0);
   assign opnd_b = hit_b_ff ? fwd_data_ff : (live_b_ff ? q_b : '0);
endmodule
`default_nettype wire

// ===== hw/rtl/rvalu_alu.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rvalu_alu
// Decode and execute of one request: R-type ALU ops, register load and read.
// ---------------------------------------------------------------------------
module rvalu_alu #(
   parameter int REG_COUNT = rvalu_pkg::REG_COUNT_DEF
) (
   input  wire rvalu_pkg::req_type         req,
   input  wire logic [rvalu_pkg::XLEN-1:0] opnd_a,
   input  wire logic [rvalu_pkg::XLEN-1:0] opnd_b,
   output rvalu_pkg::rsp_type              rsp,
   output rvalu_pkg::wr_req_type           wr_req
);
   import rvalu_pkg::*;

   logic [IDX_W-1:0] rd;
   logic [2:0]       f3;
   logic [6:0]       f7;
   logic [4:0]       sh;
   logic             alt;
   logic [XLEN-1:0]  alu_val;

   assign rd  = req.instruction_word[11:7];
   assign f3  = req.instruction_word[14:12];
   assign f7  = req.instruction_word[31:25];
   assign sh  = opnd_b[4:0];
   assign alt = (f7 == F7_ALT);

   always_comb begin
      case (f3)
         F3_ADD:  alu_val = alt ? (opnd_a - opnd_b) : (opnd_a + opnd_b);
         F3_SLL:  alu_val = opnd_a << sh;
         F3_SLT:  alu_val = XLEN'($signed(opnd_a) < $signed(opnd_b));
         F3_SLTU: alu_val = XLEN'(opnd_a < opnd_b);
         F3_XOR:  alu_val = opnd_a ^ opnd_b;
         F3_SR:   alu_val = alt ? XLEN'($signed(opnd_a) >>> sh) : (opnd_a >> sh);
         F3_OR:   alu_val = opnd_a | opnd_b;
         F3_AND:  alu_val = opnd_a & opnd_b;
         default: alu_val = '0;
      endcase
   end

   always_comb begin
      rsp    = '0;
      wr_req = '0;
      case (func_type'(req.func))
         FUNC_EXEC: begin
            rsp.dest_index = rd;
            if (f7 == F7_MULDIV) begin
               rsp.status = ST_MULDIV;
            end else if ((f3 == F3_ADD || f3 == F3_SR) && f7 != F7_BASE && f7 != F7_ALT) begin
               rsp.status = ST_RESERVED;
            end else begin
               rsp.result_value = alu_val;
               wr_req.en        = 1'b1;
               wr_req.idx       = rd;
               wr_req.data      = alu_val;
            end
         end
         FUNC_LOAD: begin
            rsp.dest_index   = req.reg_index;
            rsp.result_value = req.reg_value;
            wr_req.en        = 1'b1;
            wr_req.idx       = req.reg_index;
            wr_req.data      = req.reg_value;
         end
         FUNC_READ: begin
            rsp.dest_index   = req.reg_index;
            rsp.result_value = opnd_a;
         end
         default: begin
            rsp    = '0;
            wr_req = '0;
         end
      endcase
      rsp.wrote = wr_req.en && reg_ok(wr_req.idx, REG_COUNT);
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rv32i_register_alu_execute_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rv32i_register_alu_execute_core
// RV32I register-register ALU execute stage with its register file.
// ---------------------------------------------------------------------------
// Pipeline: execute register, then response register; one request per cycle
//   while responses are taken. The register file reads at accept and writes
//   as the request leaves execute, with same-edge write-to-read forwarding.
// Reset: pipeline emptied, all register valid bits cleared so every
//   register reads zero until written.
module rv32i_register_alu_execute_core #(
   parameter int REG_COUNT = rvalu_pkg::REG_COUNT_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   rvalu_req_if.sink     req_if,
   rvalu_rsp_if.source   rsp_if
);
   import rvalu_pkg::*;

   logic       req_accept;
   logic       s1_adv;
   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_data_ff, s1_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   rd_req_type rd_req;
   wr_req_type wr_alu;
   wr_req_type wr_req;
   logic [XLEN-1:0] opnd_a;
   logic [XLEN-1:0] opnd_b;

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      rd_req.en    = req_accept;
      rd_req.idx_a = (func_type'(req_if.func) == FUNC_READ) ? req_if.reg_index
                                                            : req_if.instruction_word[19:15];
      rd_req.idx_b = req_if.instruction_word[24:20];
   end

   rvalu_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b)
   );

   rvalu_alu #(.REG_COUNT(REG_COUNT)) u_alu (
      .req    (s1_data_ff),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .rsp    (rsp_data_in),
      .wr_req (wr_alu)
   );

   // commit the write only when the request moves on
   always_comb begin
      wr_req    = wr_alu;
      wr_req.en = wr_alu.en && s1_adv;
   end

   always_comb begin
      s1_data_in.func             = req_if.func;
      s1_data_in.instruction_word = req_if.instruction_word;
      s1_data_in.reg_index        = req_if.reg_index;
      s1_data_in.reg_value        = req_if.reg_value;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= s1_data_in;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.wrote        = rsp_data_ff.wrote;
   assign rsp_if.dest_index   = rsp_data_ff.dest_index;
   assign rsp_if.result_value = rsp_data_ff.result_value;
   assign rsp_if.status       = rsp_data_ff.status;

`ifndef SYNTHESIS
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not reach execute stage");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stalled execute stage lost its request");

   a_write_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.wrote) |-> (rsp_data_ff.status == ST_DONE))
      else $error("register written on a rejected instruction");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_DONE) |->
         (rsp_data_ff.result_value == '0 && !rsp_data_ff.wrote))
      else $error("rejected instruction carries a result");

   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr_req.en |-> (s1_valid_ff && s1_adv))
      else $error("register write without an advancing request");
`endif
endmodule
`default_nettype wire
